### rtl/bdrq_pkg.sv
// ----------------------------------------------------------------------------
// bdrq_pkg
// Shared types, sizes and helpers for the button debounce report queue.
// ----------------------------------------------------------------------------
package bdrq_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int RING_DEPTH   = 8;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int CNT_W        = RING_AW;
    localparam int SUM_W        = $clog2(2 * RING_DEPTH + BUTTON_COUNT + 1);

    localparam int PIN_W        = 4;
    localparam int STATE_W      = 4;
    localparam int QC_W         = 3;
    localparam int MAXW         = (BUTTON_COUNT > PIN_W) ? BUTTON_COUNT : PIN_W;

    localparam int LOCK_W       = 16;
    localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 16'd160;

    localparam int MIDQ_DEPTH   = 2;
    localparam int MIDQ_AW      = $clog2(MIDQ_DEPTH);
    localparam int MIDQ_CW      = $clog2(MIDQ_DEPTH + 1);

    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam logic REG_LOCKOUT = 1'b0;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIN_W-1:0] pin_levels;
    } bdrq_item_t;

    typedef struct packed {
        logic               report_valid;
        logic [STATE_W-1:0] report_state;
        logic [STATE_W-1:0] button_state;
        logic [QC_W-1:0]    queued_count;
    } bdrq_result_t;

    typedef logic [BUTTON_COUNT-1:0] bdrq_state_t;

    typedef struct packed {
        logic                               kind;
        bdrq_state_t                        push_mask;
        logic [BUTTON_COUNT-1:0][BUTTON_COUNT-1:0] reports;
        bdrq_state_t                        state;
    } bdrq_op_t;

    function automatic logic [STATE_W-1:0] to_field(input bdrq_state_t s);
        logic [MAXW-1:0] tmp;
        tmp = '0;
        tmp[BUTTON_COUNT-1:0] = s;
        return tmp[STATE_W-1:0];
    endfunction

    function automatic logic [RING_AW-1:0] ring_wrap(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] w;
        w = (v >= SUM_W'(RING_DEPTH)) ? (v - SUM_W'(RING_DEPTH)) : v;
        return w[RING_AW-1:0];
    endfunction

endpackage

### rtl/button_debounce_report_queue.sv
// ----------------------------------------------------------------------------
// button_debounce_report_queue
// Four-button lockout debouncer with a ring of button-state reports.
//
// Items enter through push/full and each gives exactly one result through
// empty/pop. A tick item samples the pins; a dequeue item pops the oldest
// report. The lockout reload value is written over the APB-style port at
// byte address 0.
// An item's result passes two registers: the debouncer writes its operation
// into the short operation queue when the item is taken, then the ring
// update writes the result register. Throughput: one item per cycle while
// results are popped as they appear, set by the ring update, which takes
// all pushes of one tick at once.
// When pop is held low the result register keeps its value; the operation
// queue absorbs up to two more items, then full rises until pop returns.
// Reset clears button state, lockout counters, ring pointers and both
// queues, and loads a lockout of 160 ticks; ring contents are not cleared.
// ----------------------------------------------------------------------------
module button_debounce_report_queue
    import bdrq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bdrq_item_t         item,
    output logic               empty,
    input  logic               pop,
    output bdrq_result_t       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [LOCK_W-1:0] lockout_ticks_reg;
    logic              in_take;
    bdrq_op_t          front_op;
    bdrq_op_t          back_op;
    logic              midq_full;
    logic              midq_ne;
    logic              back_take;

    assign pready  = 1'b1;
    assign full    = midq_full;
    assign in_take = push && !midq_full;
    assign prdata  = (paddr[2] == REG_LOCKOUT) ? PDATA_W'(lockout_ticks_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_ticks_reg <= LOCKOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_LOCKOUT))
        begin
            lockout_ticks_reg <= pwdata[LOCK_W-1:0];
        end
    end

    bdrq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_take),
        .item          (item),
        .lockout_ticks (lockout_ticks_reg),
        .op            (front_op)
    );

    bdrq_midq u_midq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_take),
        .wr_data   (front_op),
        .full      (midq_full),
        .rd_en     (back_take),
        .rd_data   (back_op),
        .not_empty (midq_ne)
    );

    bdrq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (midq_ne),
        .op       (back_op),
        .op_take  (back_take),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

### rtl/bdrq_front.sv
// ----------------------------------------------------------------------------
// bdrq_front
// Lockout debouncer: classifies items, updates button state and counters and
// emits one operation per item for the report ring.
// ----------------------------------------------------------------------------
module bdrq_front
    import bdrq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  bdrq_item_t        item,
    input  logic [LOCK_W-1:0] lockout_ticks,
    output bdrq_op_t          op
);

    bdrq_state_t       state_reg;
    bdrq_state_t       state_next;
    logic [LOCK_W-1:0] lock_reg  [BUTTON_COUNT];
    logic [LOCK_W-1:0] lock_next [BUTTON_COUNT];
    bdrq_state_t       flip;
    logic [MAXW-1:0]   pins_ext;
    logic              is_tick;

    always_comb
    begin
        pins_ext = '0;
        pins_ext[PIN_W-1:0] = item.pin_levels;
        is_tick = (item.kind == KIND_TICK);
        for (int b = 0; b < BUTTON_COUNT; b++)
        begin
            flip[b] = is_tick && (lock_reg[b] == '0) && ((~pins_ext[b]) != state_reg[b]);
            if (!is_tick)
            begin
                lock_next[b] = lock_reg[b];
            end
            else if (lock_reg[b] != '0)
            begin
                lock_next[b] = lock_reg[b] - 1'b1;
            end
            else if (flip[b])
            begin
                lock_next[b] = lockout_ticks;
            end
            else
            begin
                lock_next[b] = lock_reg[b];
            end
        end
        state_next = state_reg ^ flip;
    end

    always_comb
    begin
        op.kind      = item.kind;
        op.push_mask = flip;
        op.state     = state_next;
        for (int b = 0; b < BUTTON_COUNT; b++)
        begin
            for (int j = 0; j < BUTTON_COUNT; j++)
            begin
                op.reports[b][j] = state_reg[j] ^ (flip[j] && (j <= b));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                lock_reg[b] <= '0;
            end
        end
        else if (accept)
        begin
            state_reg <= state_next;
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                lock_reg[b] <= lock_next[b];
            end
        end
    end

endmodule

### rtl/bdrq_midq.sv
// ----------------------------------------------------------------------------
// bdrq_midq
// Short queue of operations between the debouncer and the report ring.
// ----------------------------------------------------------------------------
module bdrq_midq
    import bdrq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  bdrq_op_t wr_data,
    output logic     full,
    input  logic     rd_en,
    output bdrq_op_t rd_data,
    output logic     not_empty
);

    bdrq_op_t           slot_reg [MIDQ_DEPTH];
    logic [MIDQ_AW-1:0] wr_ptr_reg;
    logic [MIDQ_AW-1:0] rd_ptr_reg;
    logic [MIDQ_CW-1:0] count_reg;
    logic [MIDQ_CW-1:0] count_next;

    assign full      = (count_reg == MIDQ_CW'(MIDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == MIDQ_AW'(MIDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == MIDQ_AW'(MIDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/bdrq_back.sv
// ----------------------------------------------------------------------------
// bdrq_back
// Report ring and result register: carries out pushes and dequeues.
// ----------------------------------------------------------------------------
module bdrq_back
    import bdrq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         op_valid,
    input  bdrq_op_t     op,
    output logic         op_take,
    input  logic         pop,
    output logic         empty,
    output bdrq_result_t result
);

    bdrq_state_t        ring [RING_DEPTH];
    logic [RING_AW-1:0] head_reg;
    logic [RING_AW-1:0] head_next;
    logic [RING_AW-1:0] tail_reg;
    logic [RING_AW-1:0] tail_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    bdrq_result_t       result_reg;
    bdrq_result_t       result_next;
    logic [SUM_W-1:0]   n_push;
    bdrq_state_t        wr_en;
    logic [RING_AW-1:0] wr_addr [BUTTON_COUNT];
    logic               has_entry;
    logic               is_deq;

    assign op_take = op_valid && (!out_valid_reg || pop);
    assign empty   = !out_valid_reg;
    assign result  = result_reg;

    always_comb
    begin
        is_deq    = (op.kind == KIND_DEQUEUE);
        has_entry = (count_reg != '0);
        n_push    = '0;
        for (int b = 0; b < BUTTON_COUNT; b++)
        begin
            wr_en[b]   = 1'b0;
            wr_addr[b] = ring_wrap(SUM_W'(head_reg) + n_push);
            if (!is_deq && op.push_mask[b]
                && ((SUM_W'(count_reg) + n_push) < SUM_W'(RING_DEPTH - 1)))
            begin
                wr_en[b] = 1'b1;
                n_push   = n_push + 1'b1;
            end
        end

        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        result_next.report_valid = 1'b0;
        result_next.report_state = '0;
        if (is_deq)
        begin
            if (has_entry)
            begin
                tail_next  = ring_wrap(SUM_W'(tail_reg) + 1'b1);
                count_next = count_reg - 1'b1;
                result_next.report_valid = 1'b1;
                result_next.report_state = to_field(ring[tail_reg]);
            end
        end
        else
        begin
            head_next  = ring_wrap(SUM_W'(head_reg) + n_push);
            count_next = CNT_W'(SUM_W'(count_reg) + n_push);
        end
        result_next.button_state = to_field(op.state);
        result_next.queued_count = QC_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (op_take)
        begin
            for (int b = 0; b < BUTTON_COUNT; b++)
            begin
                if (wr_en[b])
                begin
                    ring[wr_addr[b]] <= op.reports[b];
                end
            end
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_take)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/bdrq_checker.sv
// ----------------------------------------------------------------------------
// bdrq_checker
// Port-level checks on the result side of the report queue, and a reset check on full.
// ----------------------------------------------------------------------------
module bdrq_checker
    import bdrq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               full,
    input  logic               empty,
    input  logic               pop,
    input  bdrq_result_t       result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while waiting for transfer");

    a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.report_valid) |-> (result.report_state == '0))
        else $error("report state set without a valid report");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_not_full: assert property (@(posedge clk)
        !rst_n |=> !full)
        else $error("input side full after reset");

endmodule

bind button_debounce_report_queue bdrq_checker u_bdrq_checker (.*);
